@@ hw/rtl/log_likelihood_keyness_assert.svh @@
// ----------------------------------------------------------------------------
// Log-likelihood keyness assertion macros
// Concurrent assertion wrappers shared by the keyness RTL modules.
// ----------------------------------------------------------------------------
`ifndef LOG_LIKELIHOOD_KEYNESS_ASSERT_SVH
`define LOG_LIKELIHOOD_KEYNESS_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LLK_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LLK_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LLK_ASSERT(lbl, clk, rst_n, prop, msg)
`define LLK_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

@@ hw/rtl/llk_pkg.sv @@
// ----------------------------------------------------------------------------
// Log-likelihood keyness package
// Shared constants and record types of the keyness block.
// ----------------------------------------------------------------------------
package llk_pkg;

	localparam int CNT_W         = 32;
	localparam int PROD_W        = 64;
	localparam int SCORE_W       = 48;
	localparam int LOG_FRAC      = 24;
	localparam int LOG_INT_W     = 6;
	localparam int LOG_W         = LOG_INT_W + LOG_FRAC;
	localparam int LOG_LAT       = LOG_FRAC + 2;
	localparam int FRAC_BITS_DEF = 16;
	localparam int QUEUE_DEPTH   = 4;

	// 2*ln(2) in Q1.31.
	localparam logic [31:0] TWO_LN2_Q31 = 32'd2977044472;

	// One classified item as the front hands it to the back.
	typedef struct packed {
		logic             invalid;
		logic             a_nz;
		logic             b_nz;
		logic [CNT_W-1:0] a;
		logic [CNT_W-1:0] b;
		logic [CNT_W-1:0] w;
		logic [CNT_W-1:0] g;
		logic [CNT_W-1:0] tg;
	} llk_rec_t;

	// Per-item flags that ride beside the log pipeline.
	typedef struct packed {
		logic             invalid;
		logic             a_nz;
		logic             b_nz;
		logic [CNT_W-1:0] a;
		logic [CNT_W-1:0] b;
	} llk_side_t;

	// Queue read side as seen by the back.
	typedef struct packed {
		logic     valid;
		llk_rec_t rec;
	} llk_qout_t;

endpackage

@@ hw/rtl/llk_front.sv @@
// ----------------------------------------------------------------------------
// Keyness front
// Input register and count classification feeding the queue.
// ----------------------------------------------------------------------------
module llk_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [llk_pkg::CNT_W-1:0] a,
	input  logic [llk_pkg::CNT_W-1:0] w,
	input  logic [llk_pkg::CNT_W-1:0] g,
	input  logic [llk_pkg::CNT_W-1:0] t,
	input  logic                     q_full,
	output logic                     push,
	output llk_pkg::llk_rec_t         rec
);

	logic                      v_q;
	logic [llk_pkg::CNT_W-1:0] a_q, w_q, g_q;
	logic [llk_pkg::CNT_W:0]   rest;

	assign in_ready = !v_q || !q_full;
	assign push     = v_q && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			a_q <= a;
			w_q <= w;
			g_q <= g;
		end
	end

	// Word total plus group size minus overlap must fit in the corpus.
	assign rest = {1'b0, w_q} + {1'b0, g_q} - {1'b0, a_q};

	always_comb begin
		rec.invalid = (t == '0) || (a_q > w_q) || (a_q > g_q) || (rest > {1'b0, t});
		rec.a       = a_q;
		rec.b       = w_q - a_q;
		rec.w       = w_q;
		rec.g       = g_q;
		rec.tg      = t - g_q;
		rec.a_nz    = (a_q != '0);
		rec.b_nz    = (w_q != a_q);
	end

endmodule

@@ hw/rtl/llk_queue.sv @@
// ----------------------------------------------------------------------------
// Keyness queue
// Small register queue between the front and the back.
// ----------------------------------------------------------------------------
`include "log_likelihood_keyness_assert.svh"

module llk_queue #(
	parameter int DEPTH = llk_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  llk_pkg::llk_rec_t  wdata,
	output logic               full,
	input  logic               pop,
	output llk_pkg::llk_qout_t qout
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	llk_pkg::llk_rec_t mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_q, rd_q;
	logic [CNT_W-1:0]  cnt_q;

	assign full       = (cnt_q == CNT_W'(DEPTH));
	assign qout.valid = (cnt_q != '0);
	assign qout.rec   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	`LLK_NEVER(a_q_overflow, clk, arst_n, push && full, "queue written while full")
	`LLK_NEVER(a_q_underflow, clk, arst_n, pop && (cnt_q == '0), "queue read while empty")
	`LLK_ASSERT(a_q_count, clk, arst_n, (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1), "queue count lost a write")

endmodule

@@ hw/rtl/llk_log2.sv @@
// ----------------------------------------------------------------------------
// Keyness log2 unit
// Pipelined base-2 logarithm of a 64-bit integer by repeated squaring.
// ----------------------------------------------------------------------------
module llk_log2 (
	input  logic                       clk,
	input  logic                       en,
	input  logic [llk_pkg::PROD_W-1:0] x,
	output logic [llk_pkg::LOG_W-1:0]  lg
);

	localparam int NF = llk_pkg::LOG_FRAC;
	localparam int NI = llk_pkg::LOG_INT_W;

	logic [NI-1:0]              msb;
	logic [NI-1:0]              msb_s1;
	logic [llk_pkg::PROD_W-1:0] x_s1;
	logic [31:0]                yn;
	logic [NI-1:0]              n_s [0:NF];
	logic [31:0]                y_s [0:NF];
	logic [NF-1:0]              f_s [0:NF];

	// Leading one position.
	always_comb begin
		msb = '0;
		for (int i = 0; i < llk_pkg::PROD_W; i++) begin
			if (x[i]) begin
				msb = NI'(i);
			end
		end
	end

	always_comb begin
		if (msb_s1 >= NI'(31)) begin
			yn = 32'(x_s1 >> (msb_s1 - NI'(31)));
		end else begin
			yn = 32'(x_s1 << (NI'(31) - msb_s1));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			msb_s1 <= msb;
			x_s1   <= x;
			n_s[0] <= msb_s1;
			y_s[0] <= yn;
			f_s[0] <= '0;
		end
	end

	// Each stage squares the mantissa and yields one fraction bit.
	for (genvar k = 0; k < NF; k++) begin : g_sq
		logic [63:0] sq;
		logic [32:0] q;
		assign sq = y_s[k] * y_s[k];
		assign q  = sq[63:31];
		always_ff @(posedge clk) begin
			if (en) begin
				n_s[k+1] <= n_s[k];
				if (q[32]) begin
					y_s[k+1] <= q[32:1];
					f_s[k+1] <= f_s[k] | (NF'(1) << (NF-1-k));
				end else begin
					y_s[k+1] <= q[31:0];
					f_s[k+1] <= f_s[k];
				end
			end
		end
	end

	assign lg = {n_s[NF], f_s[NF]};

endmodule

@@ hw/rtl/llk_back.sv @@
// ----------------------------------------------------------------------------
// Keyness back
// Products, four log pipelines, terms, scaling and the output register.
// ----------------------------------------------------------------------------
`include "log_likelihood_keyness_assert.svh"

module llk_back #(
	parameter int FRAC_BITS = llk_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  llk_pkg::llk_qout_t          qout,
	output logic                        pop,
	input  logic [llk_pkg::CNT_W-1:0]   t,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [llk_pkg::SCORE_W-1:0] out_score,
	output logic                        out_status
);

	localparam int SH  = llk_pkg::LOG_FRAC - FRAC_BITS;
	localparam int LAT = llk_pkg::LOG_LAT;
	localparam int LW  = llk_pkg::LOG_W;

	logic en;

	logic                       v_s1;
	logic [llk_pkg::PROD_W-1:0] pa_s1, pg_s1, pb_s1, pt_s1;
	llk_pkg::llk_side_t         side_s1;

	logic                       vl_s [LAT];
	llk_pkg::llk_side_t         sl_s [LAT];

	logic [LW-1:0]              la, lg, lb, lt;

	logic                       v_s2, inv_s2, an_s2, bn_s2;
	logic signed [63:0]         ta_s2, tb_s2;
	logic signed [LW:0]         da, db;
	logic signed [llk_pkg::CNT_W:0] ca, cb;
	logic signed [63:0]         ta, tb;

	logic                       v_s3, inv_s3;
	logic signed [63:0]         sum_s3;

	logic                       v_s4, inv_s4, zero_s4;
	logic [63:0]                phi_s4;
	logic [62:0]                plo_s4;

	logic [64:0]                mid;
	logic [63:0]                shv;
	logic [llk_pkg::SCORE_W-1:0] score_n;

	logic                        out_valid_q, out_status_q;
	logic [llk_pkg::SCORE_W-1:0] out_score_q;

	// The whole back advances together; it halts only when the result register is held.
	assign en  = !out_valid_q || out_ready;
	assign pop = en && qout.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int i = 0; i < LAT; i++) begin
				vl_s[i] <= 1'b0;
			end
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1    <= qout.valid;
			vl_s[0] <= v_s1;
			for (int i = 1; i < LAT; i++) begin
				vl_s[i] <= vl_s[i-1];
			end
			v_s2        <= vl_s[LAT-1];
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s1           <= qout.rec.a * t;
			pg_s1           <= qout.rec.g * qout.rec.w;
			pb_s1           <= qout.rec.b * t;
			pt_s1           <= qout.rec.tg * qout.rec.w;
			side_s1.invalid <= qout.rec.invalid;
			side_s1.a_nz    <= qout.rec.a_nz;
			side_s1.b_nz    <= qout.rec.b_nz;
			side_s1.a       <= qout.rec.a;
			side_s1.b       <= qout.rec.b;
			sl_s[0]         <= side_s1;
			for (int i = 1; i < LAT; i++) begin
				sl_s[i] <= sl_s[i-1];
			end
		end
	end

	llk_log2 u_log_a (.clk(clk), .en(en), .x(pa_s1), .lg(la));
	llk_log2 u_log_g (.clk(clk), .en(en), .x(pg_s1), .lg(lg));
	llk_log2 u_log_b (.clk(clk), .en(en), .x(pb_s1), .lg(lb));
	llk_log2 u_log_t (.clk(clk), .en(en), .x(pt_s1), .lg(lt));

	assign da = $signed({1'b0, la}) - $signed({1'b0, lg});
	assign db = $signed({1'b0, lb}) - $signed({1'b0, lt});
	assign ca = $signed({1'b0, sl_s[LAT-1].a});
	assign cb = $signed({1'b0, sl_s[LAT-1].b});
	assign ta = ca * da;
	assign tb = cb * db;

	always_ff @(posedge clk) begin
		if (en) begin
			ta_s2  <= ta;
			tb_s2  <= tb;
			inv_s2 <= sl_s[LAT-1].invalid;
			an_s2  <= sl_s[LAT-1].a_nz;
			bn_s2  <= sl_s[LAT-1].b_nz;

			sum_s3 <= (an_s2 ? ta_s2 : 64'sd0) + (bn_s2 ? tb_s2 : 64'sd0);
			inv_s3 <= inv_s2;

			// Positive sum split at bit 31 so each half fits one multiplier.
			phi_s4  <= 64'(sum_s3[62:31]) * 64'(llk_pkg::TWO_LN2_Q31);
			plo_s4  <= 63'(sum_s3[30:0]) * 63'(llk_pkg::TWO_LN2_Q31);
			inv_s4  <= inv_s3;
			zero_s4 <= inv_s3 || sum_s3[63] || (sum_s3 == 64'sd0);
		end
	end

	assign mid = {1'b0, phi_s4} + 65'(plo_s4[62:31]);
	assign shv = mid[63:0] >> SH;

	always_comb begin
		if (zero_s4) begin
			score_n = '0;
		end else if (mid[64] || (shv[63:llk_pkg::SCORE_W] != '0)) begin
			score_n = '1;
		end else begin
			score_n = shv[llk_pkg::SCORE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_score_q  <= score_n;
			out_status_q <= inv_s4;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_score  = out_score_q;
	assign out_status = out_status_q;

	`LLK_ASSERT(a_bad_is_zero, clk, arst_n, (out_valid_q && out_status_q) |-> (out_score_q == '0), "bad score")
	`LLK_ASSERT(a_pop_needs_en, clk, arst_n, pop |-> en, "queue read while back is halted")
	`LLK_ASSERT(a_out_hold, clk, arst_n, (out_valid_q && !out_ready) |=> $stable(out_score_q), "held beat")

endmodule

@@ hw/rtl/log_likelihood_keyness.sv @@
// ----------------------------------------------------------------------------
// Log-likelihood keyness
// Streams word and group counts in and G2 keyness scores out.
// ----------------------------------------------------------------------------
// Each slave beat carries the counts of one word in one group; the block
// returns exactly one master beat per slave beat, in order: the score as an
// unsigned fixed-point value with FRAC_BITS fraction bits, saturating at
// 48 bits, and a status flag in tuser. The status is set, with a zero score,
// when the corpus total is zero or the counts cannot belong to one table.
// The corpus total must be written through cfg_we/cfg_wdata by the user only
// while the block idles; the block itself does not enforce this. Throughput
// is one beat per cycle while the receiver is ready. Each beat passes the
// input register, queue, product stage, 26 stages of each log2 pipeline (24
// of them one squaring multiplier each), term, sum, scaling and the output
// register. The four log2 pipelines and the product multipliers set that
// depth. A stalled receiver holds the output register and freezes the back;
// the front keeps taking beats until the four-entry queue fills, then drops
// s_tready. Reset clears all valid flags and the corpus total.
// ----------------------------------------------------------------------------
module log_likelihood_keyness #(
	parameter int FRAC_BITS   = llk_pkg::FRAC_BITS_DEF,
	parameter int QUEUE_DEPTH = llk_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // word_in_group [31:0], word_total [63:32], group_words [95:64]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // score [47:0]
	output logic        m_tuser    // status [0]
);

	logic [llk_pkg::CNT_W-1:0] corpus_total_q;
	logic                      push, q_full, pop;
	llk_pkg::llk_rec_t         rec;
	llk_pkg::llk_qout_t        qout;

	// The user changes the corpus total only between runs; unchecked, it feeds both ends directly.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corpus_total_q <= '0;
		end else if (cfg_we) begin
			corpus_total_q <= cfg_wdata;
		end
	end

	llk_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.a        (s_tdata[31:0]),
		.w        (s_tdata[63:32]),
		.g        (s_tdata[95:64]),
		.t        (corpus_total_q),
		.q_full   (q_full),
		.push     (push),
		.rec      (rec)
	);

	llk_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (rec),
		.full   (q_full),
		.pop    (pop),
		.qout   (qout)
	);

	llk_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.qout       (qout),
		.pop        (pop),
		.t          (corpus_total_q),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_score  (m_tdata),
		.out_status (m_tuser)
	);

endmodule

@@ dv/log_likelihood_keyness_test.sv @@
// ----------------------------------------------------------------------------
// Log-likelihood keyness testbench
// Drives count triples into the keyness block across several corpus totals
// and idling phases, predicts each score and status in fixed point, and
// checks every master beat in order against the predicted queue.
// ----------------------------------------------------------------------------
module log_likelihood_keyness_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC_BITS = llk_pkg::FRAC_BITS_DEF;
	localparam int LOG_FRAC = llk_pkg::LOG_FRAC;
	localparam logic [47:0] SCORE_SAT = 48'hFFFF_FFFF_FFFF;
	localparam int DRAIN_CYCLES = 80;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] w;
		logic [31:0] g;
	} counts_t;

	typedef struct packed {
		logic [47:0] score;
		logic        status;
	} keyness_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [31:0] cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic        m_tuser;

	// Percentages of cycles in which each side idles; changed between phases.
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;

	counts_t  pending_counts[$];
	keyness_t expected_scores[$];
	logic [31:0] corpus_total;
	int unsigned error_count;
	bit stimulus_done;
	logic s_tready_seen;

	log_likelihood_keyness dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic add_item(counts_t c);
		pending_counts = {pending_counts, c};
	endtask

	// log2 of x >= 1 in Q6.24: integer part from the top set bit, then the
	// fraction bits by repeated squaring of the normalized mantissa.
	function automatic longint unsigned log2_q24(longint unsigned x);
		int n;
		longint unsigned y;
		longint unsigned r;
		n = 63;
		while (n > 0 && x[n] == 1'b0)
			n--;
		if (n >= 31)
			y = x >> (n - 31);
		else
			y = x << (31 - n);
		r = longint'(n) << LOG_FRAC;
		for (int i = LOG_FRAC - 1; i >= 0; i--) begin
			y = (y * y) >> 31;
			if (y >= 64'h1_0000_0000) begin
				y = y >> 1;
				r[i] = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic longint g2_term(longint unsigned cnt, longint unsigned num,
	                                   longint unsigned den);
		longint diff;
		diff = longint'(log2_q24(num)) - longint'(log2_q24(den));
		return longint'(cnt) * diff;
	endfunction

	function automatic keyness_t predict_keyness(counts_t c, logic [31:0] total);
		keyness_t res;
		longint unsigned a, w, g, t, b, us, p_hi, p_lo, mid;
		longint s;
		a = c.a;
		w = c.w;
		g = c.g;
		t = total;
		res = '0;
		if (t == 0 || a > w || a > g || (w + g - a) > t) begin
			res.status = 1'b1;
			return res;
		end
		b = w - a;
		s = 0;
		if (a > 0)
			s += g2_term(a, a * t, g * w);
		if (b > 0)
			s += g2_term(b, b * t, (t - g) * w);
		if (s > 0) begin
			us = longint'(s);
			p_hi = (us >> 31) * 64'd2977044472;
			p_lo = (us & 64'h7FFF_FFFF) * 64'd2977044472;
			mid = p_hi + (p_lo >> 31);
			if (mid < p_hi)
				res.score = SCORE_SAT;
			else if ((mid >> (LOG_FRAC - FRAC_BITS)) > {16'd0, SCORE_SAT})
				res.score = SCORE_SAT;
			else
				res.score = 48'(mid >> (LOG_FRAC - FRAC_BITS));
		end
		return res;
	endfunction

	// Driver: inputs change on the falling edge. A beat taken at the rising
	// edge is popped here before the next item is presented. word_in_group
	// goes in the lowest 32 bits of the beat.
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready_seen)
				void'(pending_counts.pop_front());
			if (pending_counts.size() > 0 && ($urandom_range(99) >= send_idle_pct)) begin
				s_tvalid <= 1'b1;
				s_tdata <= {pending_counts[0].g, pending_counts[0].w, pending_counts[0].a};
			end else if (!(s_tvalid && !s_tready_seen)) begin
				s_tvalid <= 1'b0;
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Handshakes sampled at the rising edge; the driver consumes the flag.
	always @(posedge clk) begin
		s_tready_seen <= s_tready;
		if (arst_n && s_tvalid && s_tready)
			expected_scores = {expected_scores,
			                   predict_keyness('{s_tdata[31:0], s_tdata[63:32],
			                                     s_tdata[95:64]}, corpus_total)};
	end

	// Monitor: each master beat is checked against the oldest prediction.
	always @(posedge clk) begin
		keyness_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_scores.size() == 0) begin
				error_count++;
				$display("%0t: unexpected beat score=%h status=%b", $time, m_tdata, m_tuser);
			end else begin
				want = expected_scores.pop_front();
				if (m_tdata !== want.score) begin
					error_count++;
					$display("%0t: score expected %h actual %h", $time, want.score, m_tdata);
				end
				if (m_tuser !== want.status) begin
					error_count++;
					$display("%0t: status expected %b actual %b", $time, want.status,
					         m_tuser);
				end
			end
		end
	end

	// A valid triple under total t: a <= g, a <= w, w + g - a <= t.
	function automatic counts_t valid_counts(logic [31:0] t, bit tiny);
		counts_t c;
		longint unsigned g, w, a, lim;
		if (t == 0)
			return counts_t'({$urandom, $urandom, $urandom});
		lim = tiny ? ((t < 1000) ? t : 1000) : t;
		g = {$urandom, $urandom} % (lim + 1);
		a = (g == 0) ? 0 : {$urandom, $urandom} % (g + 1);
		w = a + {$urandom, $urandom} % (t - g + 1);
		c.a = a[31:0];
		c.w = w[31:0];
		c.g = g[31:0];
		return c;
	endfunction

	task automatic wait_idle();
		while (pending_counts.size() > 0 || expected_scores.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_total(logic [31:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		corpus_total = value;
	endtask

	task automatic queue_random(int unsigned count);
		counts_t c;
		for (int unsigned i = 0; i < count; i++) begin
			case ($urandom_range(9))
				0: c = counts_t'({$urandom, $urandom, $urandom});
				1, 2: c = valid_counts(corpus_total, 1'b1);
				default: c = valid_counts(corpus_total, 1'b0);
			endcase
			add_item(c);
		end
	endtask

	initial begin
		logic [31:0] totals[6];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		s_tready_seen = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		error_count = 0;
		stimulus_done = 1'b0;
		corpus_total = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Zero total straight after reset: everything must flag status.
		add_item('{32'd0, 32'd0, 32'd0});
		add_item('{32'd5, 32'd10, 32'd20});
		wait_idle();

		write_total(32'd1000);
		add_item('{32'd0, 32'd10, 32'd100});     // first term dropped
		add_item('{32'd10, 32'd10, 32'd100});    // second term dropped
		add_item('{32'd0, 32'd0, 32'd100});      // both dropped
		add_item('{32'd11, 32'd10, 32'd100});    // a above w
		add_item('{32'd5, 32'd10, 32'd4});       // a above g
		add_item('{32'd0, 32'd600, 32'd500});    // cell negative
		add_item('{32'd10, 32'd100, 32'd100});   // zero sum
		add_item('{32'd50, 32'd100, 32'd100});
		add_item('{32'd100, 32'd100, 32'd100});
		add_item('{32'd0, 32'd1000, 32'd0});
		wait_idle();

		write_total(32'hFFFF_FFFF);
		add_item('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
		add_item('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
		add_item('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000});
		add_item('{32'd1, 32'd1, 32'd1});
		add_item('{32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'hFFFF_FFFE});
		add_item('{32'h1, 32'h1, 32'hFFFF_FFFF});
		add_item('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0});
		wait_idle();

		totals = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'd123456, 32'h8000_0000, 32'd1000};
		for (int ph = 0; ph < 6; ph++) begin
			write_total(ph < 4 ? totals[ph] : $urandom);
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
				default: begin send_idle_pct = 17; recv_stall_pct = 17; end
			endcase
			queue_random(100);
			// Sender holds off until everything in flight has come back.
			while (expected_scores.size() > 0 || pending_counts.size() > 0)
				@(posedge clk);
			queue_random(100);
			wait_idle();
		end
		stimulus_done = 1'b1;
	end

	initial begin
		wait (stimulus_done);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#5ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/llk_pkg.sv
hw/rtl/llk_front.sv
hw/rtl/llk_queue.sv
hw/rtl/llk_log2.sv
hw/rtl/llk_back.sv
hw/rtl/log_likelihood_keyness.sv
dv/log_likelihood_keyness_test.sv
